FILE: src/lfia_pkg.sv
// lfia_pkg: shared constants, codes and types of the lowest free index allocator
// used by lowest_free_index_allocator and lfia_checker, no dependencies
`timescale 1ns / 1ps

package lfia_pkg;

    localparam int MAX_INDICES = 256;
    localparam int WORD_W      = 32;
    localparam int NUM_WORDS   = MAX_INDICES / WORD_W;
    localparam int WORD_AW     = $clog2(NUM_WORDS);
    localparam int BIT_AW      = $clog2(WORD_W);
    localparam int IDX_W       = 8;
    localparam int MARK_W      = 9;
    localparam int CNT_W       = 9;
    localparam int OP_W        = 2;
    localparam int ST_W        = 2;
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 24;

    typedef logic [OP_W-1:0] op_t;
    typedef logic [ST_W-1:0] status_t;

    localparam op_t OP_ALLOC = 2'd0;
    localparam op_t OP_FREE  = 2'd1;
    localparam op_t OP_CLEAR = 2'd2;

    localparam status_t ST_OK         = 2'd0;
    localparam status_t ST_FULL       = 2'd1;
    localparam status_t ST_NOT_IN_USE = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_TRIM,
        S_RESULT
    } state_t;

endpackage

FILE: src/lowest_free_index_allocator.sv
// lowest_free_index_allocator: hands out the lowest freed index or else the index at the mark
// depends on lfia_pkg
`timescale 1ns / 1ps
//
// channel | dir | beat contents
// s_*     | in  | s_tdata: operation[1:0], index[9:2]
// m_*     | out | m_tdata: granted_index[7:0], status[9:8], live_count[18:10]
//
// allocate: one free-map word checked per cycle in the scan loop
// free of a top index other than 0: one word trimmed per cycle
// reset clears the free map, mark and count at once, no sweep
// s_tready is low while a request is in work; a result waits in the output register

module lowest_free_index_allocator (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [lfia_pkg::IN_TDATA_W-1:0]  s_tdata,  // operation, index
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [lfia_pkg::OUT_TDATA_W-1:0] m_tdata   // granted_index, status, live_count
);

    import lfia_pkg::*;

    function automatic logic [BIT_AW-1:0] low_bit(input logic [WORD_W-1:0] w);
        logic [WORD_W-1:0] iso;
        logic [BIT_AW-1:0] r;
        iso = w & (~w + WORD_W'(1));
        r   = '0;
        for (int b = 0; b < BIT_AW; b++)
        begin
            for (int i = 0; i < WORD_W; i++)
            begin
                if (((i >> b) & 1) == 1)
                begin
                    r[b] = r[b] | iso[i];
                end
            end
        end
        return r;
    endfunction

    function automatic logic [BIT_AW-1:0] high_bit(input logic [WORD_W-1:0] w);
        logic [WORD_W-1:0] rev;
        for (int i = 0; i < WORD_W; i++)
        begin
            rev[i] = w[WORD_W-1-i];
        end
        return ~low_bit(rev);
    endfunction

    state_t state_reg, state_next;

    logic [NUM_WORDS-1:0][WORD_W-1:0] map_reg;
    logic [MARK_W-1:0]  mark_reg, mark_next;
    logic [CNT_W-1:0]   live_reg, live_next;
    logic [IDX_W-1:0]   gnt_reg, gnt_next;
    status_t            st_reg, st_next;
    logic [WORD_AW-1:0] cnt_reg, cnt_next;
    logic               m_tvalid_reg;
    logic [OUT_TDATA_W-1:0] m_tdata_reg;

    logic               s_accept;
    logic               out_free;
    op_t                in_op;
    logic [IDX_W-1:0]   in_idx;
    logic [MARK_W-1:0]  in_idx_ext;
    logic               free_ok;
    logic               free_top;
    logic [IDX_W-1:0]   trim_pos;
    logic [WORD_AW-1:0] rd_addr;
    logic [WORD_W-1:0]  rd_word;
    logic               scan_hit;
    logic               scan_last;
    logic [BIT_AW-1:0]  low_pos;
    logic [WORD_W-1:0]  trim_mask;
    logic [WORD_W-1:0]  holes;
    logic               trim_all;
    logic [BIT_AW-1:0]  high_hole;
    logic               map_we;
    logic               map_clr;
    logic [WORD_W-1:0]  map_wd;

    assign in_op      = s_tdata[OP_W-1:0];
    assign in_idx     = s_tdata[OP_W+IDX_W-1:OP_W];
    assign in_idx_ext = {1'b0, in_idx};
    assign s_accept   = s_tvalid && s_tready;
    assign out_free   = !m_tvalid_reg || m_tready;
    assign trim_pos   = mark_reg[IDX_W-1:0] - IDX_W'(1);

    // single read port into the free map
    always_comb
    begin
        unique case (state_reg)
            S_IDLE:  rd_addr = in_idx[IDX_W-1:BIT_AW];
            S_SCAN:  rd_addr = cnt_reg;
            S_TRIM:  rd_addr = trim_pos[IDX_W-1:BIT_AW];
            default: rd_addr = cnt_reg;
        endcase
    end

    assign rd_word   = map_reg[rd_addr];
    assign scan_hit  = |rd_word;
    assign scan_last = (cnt_reg == WORD_AW'(NUM_WORDS - 1));
    assign low_pos   = low_bit(rd_word);
    assign trim_mask = {WORD_W{1'b1}} >> (~trim_pos[BIT_AW-1:0]);
    assign holes     = ~rd_word & trim_mask;
    assign trim_all  = (holes == '0);
    assign high_hole = high_bit(holes);
    assign free_ok   = (in_idx_ext < mark_reg) && !rd_word[in_idx[BIT_AW-1:0]];
    assign free_top  = ((in_idx_ext + MARK_W'(1)) == mark_reg);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_accept)
                begin
                    case (in_op)
                        OP_ALLOC: state_next = S_SCAN;
                        OP_FREE:
                        begin
                            if (free_ok && free_top && in_idx != '0)
                            begin
                                state_next = S_TRIM;
                            end
                            else
                            begin
                                state_next = S_RESULT;
                            end
                        end
                        default:  state_next = S_RESULT;
                    endcase
                end
            end
            S_SCAN:
            begin
                if (scan_hit || scan_last)
                begin
                    state_next = S_RESULT;
                end
            end
            S_TRIM:
            begin
                if (!trim_all || trim_pos[IDX_W-1:BIT_AW] == '0)
                begin
                    state_next = S_RESULT;
                end
            end
            S_RESULT:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        s_tready = (state_reg == S_IDLE);
        m_tvalid = m_tvalid_reg;
        m_tdata  = m_tdata_reg;
    end

    // datapath
    always_comb
    begin
        map_we    = 1'b0;
        map_clr   = 1'b0;
        map_wd    = rd_word;
        mark_next = mark_reg;
        live_next = live_reg;
        gnt_next  = gnt_reg;
        st_next   = st_reg;
        cnt_next  = cnt_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_accept)
                begin
                    gnt_next = '0;
                    st_next  = ST_OK;
                    cnt_next = '0;
                    case (in_op)
                        OP_FREE:
                        begin
                            if (!free_ok)
                            begin
                                st_next = ST_NOT_IN_USE;
                            end
                            else
                            begin
                                live_next = live_reg - CNT_W'(1);
                                if (free_top)
                                begin
                                    mark_next = in_idx_ext;
                                end
                                else
                                begin
                                    map_we = 1'b1;
                                    map_wd = rd_word | (WORD_W'(1) << in_idx[BIT_AW-1:0]);
                                end
                            end
                        end
                        OP_CLEAR:
                        begin
                            map_clr   = 1'b1;
                            mark_next = '0;
                            live_next = '0;
                        end
                        default: ;
                    endcase
                end
            end
            S_SCAN:
            begin
                if (scan_hit)
                begin
                    map_we    = 1'b1;
                    map_wd    = rd_word & ~(WORD_W'(1) << low_pos);
                    gnt_next  = {cnt_reg, low_pos};
                    live_next = live_reg + CNT_W'(1);
                end
                else if (scan_last)
                begin
                    if (mark_reg < MARK_W'(MAX_INDICES))
                    begin
                        gnt_next  = mark_reg[IDX_W-1:0];
                        mark_next = mark_reg + MARK_W'(1);
                        live_next = live_reg + CNT_W'(1);
                    end
                    else
                    begin
                        st_next = ST_FULL;
                    end
                end
                else
                begin
                    cnt_next = cnt_reg + WORD_AW'(1);
                end
            end
            S_TRIM:
            begin
                map_we = 1'b1;
                if (trim_all)
                begin
                    map_wd    = '0;
                    mark_next = {1'b0, trim_pos[IDX_W-1:BIT_AW], {BIT_AW{1'b0}}};
                end
                else
                begin
                    // keep bits up to and including the highest hole
                    map_wd    = rd_word & ({WORD_W{1'b1}} >> (~high_hole));
                    mark_next = {1'b0, trim_pos[IDX_W-1:BIT_AW], high_hole} + MARK_W'(1);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            map_reg      <= '0;
            mark_reg     <= '0;
            live_reg     <= '0;
            cnt_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            mark_reg  <= mark_next;
            live_reg  <= live_next;
            cnt_reg   <= cnt_next;
            if (map_clr)
            begin
                map_reg <= '0;
            end
            else if (map_we)
            begin
                map_reg[rd_addr] <= map_wd;
            end
            if (state_reg == S_RESULT && out_free)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        gnt_reg <= gnt_next;
        st_reg  <= st_next;
        if (state_reg == S_RESULT && out_free)
        begin
            m_tdata_reg <= {(OUT_TDATA_W - IDX_W - ST_W - CNT_W)'(0), live_reg, st_reg, gnt_reg};
        end
    end

endmodule

FILE: src/lfia_checker.sv
// lfia_checker: port-level assertions for lowest_free_index_allocator
// depends on lfia_pkg, bound into lowest_free_index_allocator at the end of this file
`timescale 1ns / 1ps

module lfia_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             s_tvalid,
    input logic                             s_tready,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [lfia_pkg::OUT_TDATA_W-1:0] m_tdata   // granted_index, status, live_count
);

    import lfia_pkg::*;

    logic [IDX_W-1:0] out_gnt;
    status_t          out_st;
    logic [CNT_W-1:0] out_live;

    assign out_gnt  = m_tdata[IDX_W-1:0];
    assign out_st   = m_tdata[IDX_W+ST_W-1:IDX_W];
    assign out_live = m_tdata[IDX_W+ST_W+CNT_W-1:IDX_W+ST_W];

    // stalled beat holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output beat changed while stalled");

    a_live_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> out_live <= CNT_W'(MAX_INDICES))
        else $error("live count above capacity");

    a_gnt_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && out_st != ST_OK |-> out_gnt == '0)
        else $error("granted index nonzero on error");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && out_st == ST_FULL |-> out_live == CNT_W'(MAX_INDICES))
        else $error("full reported below capacity");

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request taken while busy");

endmodule

bind lowest_free_index_allocator lfia_checker u_lfia_checker (.*);

FILE: test/lowest_free_index_allocator_test.sv
// lowest_free_index_allocator_test: stream testbench with its own allocation tracker
// drives allocate, free, clear and unused requests, checks every result beat field by field
// depends on lfia_pkg and lowest_free_index_allocator
`timescale 1ns / 1ps

module lowest_free_index_allocator_test;

    import lfia_pkg::*;

    localparam int  HALF_PERIOD  = 6;
    localparam int  ITEM_TARGET  = 1400;
    localparam int  LIMIT_CYCLES = 600000;
    localparam int  IDLE_PCT     = 28;
    localparam int  HOLD_CYCLES  = 150;
    localparam int  SETTLE       = 16;
    localparam op_t OP_UNUSED    = 2'd3;

    localparam int SEG_FILL   = 0;
    localparam int SEG_GROW   = 1;
    localparam int SEG_SHRINK = 2;
    localparam int SEG_CHURN  = 3;

    typedef struct packed {
        logic [IDX_W-1:0] granted;
        status_t          status;
        logic [CNT_W-1:0] live;
    } grant_t;

    class allocation_tracker;
        bit     freed[MAX_INDICES];
        int     mark;
        int     live;
        int     errors;
        grant_t awaited[$];

        function new();
            errors = 0;
            clear_all();
        endfunction

        function void clear_all();
            foreach (freed[i])
                freed[i] = 1'b0;
            mark = 0;
            live = 0;
        endfunction

        // allocate: lowest-free search, then mark bump, then full; free and clear also update the state
        function void note_request(op_t op, logic [IDX_W-1:0] idx);
            grant_t want;
            int     i;
            want.granted = '0;
            want.status  = ST_OK;
            case (op)
                OP_ALLOC:
                begin
                    i = 0;
                    while (i < mark && !freed[i])
                        i++;
                    if (i < mark)
                    begin
                        freed[i] = 1'b0;
                        want.granted = IDX_W'(i);
                        live++;
                    end
                    else if (mark < MAX_INDICES)
                    begin
                        want.granted = IDX_W'(mark);
                        mark++;
                        live++;
                    end
                    else
                        want.status = ST_FULL;
                end
                OP_FREE:
                begin
                    if (int'(idx) >= mark || freed[idx])
                        want.status = ST_NOT_IN_USE;
                    else
                    begin
                        if (int'(idx) + 1 == mark)
                        begin
                            // top index: drop the mark past trailing free entries
                            mark--;
                            while (mark > 0 && freed[mark-1])
                            begin
                                freed[mark-1] = 1'b0;
                                mark--;
                            end
                        end
                        else
                            freed[idx] = 1'b1;
                        live--;
                    end
                end
                OP_CLEAR:
                    clear_all();
                default:
                    ;
            endcase
            want.live = CNT_W'(live);
            awaited.push_back(want);
        endfunction

        function void check_grant(logic [OUT_TDATA_W-1:0] beat);
            grant_t got;
            grant_t want;
            got.granted = beat[IDX_W-1:0];
            got.status  = beat[IDX_W+ST_W-1:IDX_W];
            got.live    = beat[IDX_W+ST_W+CNT_W-1:IDX_W+ST_W];
            if (awaited.size() == 0)
            begin
                $display("%0t: result beat with nothing expected, expected none, actual %h",
                         $time, beat);
                errors++;
                return;
            end
            want = awaited.pop_front();
            if (got.granted !== want.granted)
            begin
                $display("%0t: granted_index expected %0d actual %0d",
                         $time, want.granted, got.granted);
                errors++;
            end
            if (got.status !== want.status)
            begin
                $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
                errors++;
            end
            if (got.live !== want.live)
            begin
                $display("%0t: live_count expected %0d actual %0d", $time, want.live, got.live);
                errors++;
            end
        endfunction

        // random index that is currently handed out, or any index when none is
        function logic [IDX_W-1:0] pick_live();
            int i;
            int n;
            if (live == 0)
                return IDX_W'($urandom_range(0, MAX_INDICES-1));
            i = $urandom_range(0, mark-1);
            for (n = 0; n < mark; n++)
            begin
                if (!freed[i])
                    return IDX_W'(i);
                i = (i + 1) % mark;
            end
            return IDX_W'(i);
        endfunction
    endclass

    logic                   clk;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;   // operation, index
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;   // granted_index, status, live_count

    allocation_tracker ledger;
    bit                send_idle_on;
    bit                recv_idle_on;
    int                items_sent;
    int                hold_requests;
    int                hold_seen;
    int                hold_left;
    int                cycles;

    lowest_free_index_allocator DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #HALF_PERIOD clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("lowest_free_index_allocator: mismatch");
            $finish;
        end
    end

    // receiver: checks accepted beats, stalls at random or for a long hold
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            ledger.check_grant(m_tdata);
        if (hold_seen != hold_requests)
        begin
            hold_seen = hold_requests;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else if (recv_idle_on)
            m_tready <= ($urandom_range(0, 99) >= IDLE_PCT);
        else
            m_tready <= 1'b1;
    end

    task automatic send_beat(input op_t op, input logic [IDX_W-1:0] idx);
        while (send_idle_on && $urandom_range(0, 99) < IDLE_PCT)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(IN_TDATA_W-IDX_W-OP_W){1'b0}}, idx, op};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        ledger.note_request(op, idx);
        items_sent++;
    endtask

    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        while (ledger.awaited.size() != 0)
            @(posedge clk);
    endtask

    task automatic send_mix(input int alloc_pct, input int beats);
        int r;
        repeat (beats)
        begin
            r = $urandom_range(0, 99);
            if (r < 1)
                send_beat(OP_CLEAR, IDX_W'($urandom));
            else if (r < 3)
                send_beat(OP_UNUSED, IDX_W'($urandom));
            else if (r < 7)
                send_beat(OP_FREE, IDX_W'($urandom));
            else if ($urandom_range(0, 99) < alloc_pct)
                send_beat(OP_ALLOC, IDX_W'($urandom));
            else
                send_beat(OP_FREE, ledger.pick_live());
        end
    endtask

    initial
    begin
        int seg;
        int mode;
        ledger        = new();
        rst_n         = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        m_tready      = 1'b0;
        send_idle_on  = 1'b1;
        recv_idle_on  = 1'b1;
        items_sent    = 0;
        hold_requests = 0;
        hold_seen     = 0;
        hold_left     = 0;
        cycles        = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: first grant, bad frees, trim to bottom, holes, trim past holes
        send_beat(OP_ALLOC, 8'hFF);
        send_beat(OP_FREE, 8'hFF);
        send_beat(OP_FREE, 8'h00);
        send_beat(OP_FREE, 8'h00);
        repeat (4) send_beat(OP_ALLOC, 8'h00);
        send_beat(OP_FREE, 8'h01);
        send_beat(OP_FREE, 8'h02);
        send_beat(OP_FREE, 8'h01);
        send_beat(OP_FREE, 8'h03);
        send_beat(OP_UNUSED, 8'hAA);
        send_beat(OP_ALLOC, 8'h55);
        send_beat(OP_ALLOC, 8'h00);
        send_beat(OP_FREE, 8'h01);
        send_beat(OP_ALLOC, 8'hFF);
        send_beat(OP_CLEAR, 8'hFF);
        send_beat(OP_FREE, 8'h00);
        send_beat(OP_ALLOC, 8'h00);
        send_beat(OP_UNUSED, 8'h55);
        send_beat(OP_CLEAR, 8'h00);

        seg = 0;
        while (items_sent < ITEM_TARGET)
        begin
            mode = (seg == 0) ? SEG_FILL : $urandom_range(SEG_FILL, SEG_CHURN);
            send_idle_on = (seg != 3);
            recv_idle_on = (seg != 3);
            if (seg == 1)
                hold_requests++;
            case (mode)
                SEG_FILL:
                begin
                    while (ledger.live < MAX_INDICES)
                        send_beat(OP_ALLOC, IDX_W'($urandom));
                    repeat (3) send_beat(OP_ALLOC, IDX_W'($urandom));
                    send_beat(OP_FREE, IDX_W'(MAX_INDICES-1));
                    send_beat(OP_ALLOC, 8'h00);
                end
                SEG_GROW:
                    send_mix(85, $urandom_range(40, 120));
                SEG_SHRINK:
                    send_mix(20, $urandom_range(40, 120));
                default:
                    send_mix(50, $urandom_range(40, 120));
            endcase
            if (seg == 0 || $urandom_range(0, 99) < 25)
                wait_for_results();
            seg++;
        end
        wait_for_results();
        repeat (SETTLE) @(posedge clk);
        if (ledger.errors == 0)
            $display("lowest_free_index_allocator: match");
        else
            $display("lowest_free_index_allocator: mismatch");
        $finish;
    end

endmodule
